/* sv/ppa_pkg.sv */
package ppa_pkg;

    localparam logic [2:0] ZC_NONE   = 3'd0;
    localparam logic [2:0] ZC_MANUAL = 3'd1;
    localparam logic [2:0] ZC_TIMED  = 3'd2;
    localparam logic [2:0] ZC_APPLY  = 3'd3;
    localparam logic [2:0] ZC_CANCEL = 3'd4;

    localparam logic [1:0] REG_WINDOW    = 2'd0;
    localparam logic [1:0] REG_DYN_GAIN  = 2'd1;
    localparam logic [1:0] REG_STAT_GAIN = 2'd2;

    localparam logic signed [47:0] S24_MAX = 48'sd8388607;
    localparam logic signed [47:0] S24_MIN = -48'sd8388608;

    typedef struct packed {
        logic clear;
        logic capture;
        logic apply;
    } t_lane_ctrl;

    function automatic logic signed [23:0] f_sat24(input logic signed [47:0] v);
        logic signed [23:0] r;
        if (v > S24_MAX) begin
            r = 24'sh7FFFFF;
        end else if (v < S24_MIN) begin
            r = 24'sh800000;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

endpackage

/* sv/pitot_pressure_averager.sv */
// Each accepted item yields a valid result once the bit-serial divider in each lane has
// finished; an apply step adds the zero-offset sum, scaling and update after the divide.
// The input is not ready for a new item until the result of the last one is registered;
// a stalled result holds the lanes.
// Reset (synchronous, active low) restores the register defaults, empties the
// averaging windows and clears the offsets and the auto-zero sequencer.
module pitot_pressure_averager #(
    parameter int WINDOW_DEPTH = 512,
    parameter int ZERO_SAMPLES = 5
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // Fields from bit 0: dyn_sample[23:0], stat_sample[47:24].
    input  logic [47:0] i_s_axis_tdata,
    // Fields from bit 0: zero_cmd[2:0].
    input  logic [2:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // Fields from bit 0: dyn_press[22:0], stat_press[47:23], total_press[72:48].
    output logic [79:0] o_m_axis_tdata,
    // Fields from bit 0: reversed[0], zero_phase[2:1].
    output logic [2:0]  o_m_axis_tuser,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    localparam int WW  = $clog2(WINDOW_DEPTH + 1);
    localparam int EW  = (WW > 10 ? WW : 10) + 1;
    localparam int ZI  = ZERO_SAMPLES > 1 ? $clog2(ZERO_SAMPLES) : 1;
    localparam int ZCW = $clog2(ZERO_SAMPLES + 1);

    localparam logic [1:0] ZM_IDLE   = 2'd0;
    localparam logic [1:0] ZM_MANUAL = 2'd1;
    localparam logic [1:0] ZM_TIMED  = 2'd2;
    localparam logic [1:0] ZM_APPLY  = 2'd3;

    typedef enum logic {T_IDLE, T_BUSY} t_tstate;

    t_tstate             r_state;
    logic [9:0]          r_window;
    logic [15:0]         r_dyn_gain;
    logic [15:0]         r_stat_gain;
    logic [1:0]          r_zmode;
    logic [ZI-1:0]       r_zidx;
    logic [ZCW-1:0]      r_zcnt;
    logic                r_valid;
    logic [79:0]         r_data;
    logic [2:0]          r_user;

    logic [WW-1:0]       eff_w;
    logic                win_clr;
    logic                accept;
    logic                ack;
    logic [1:0]          n_m;
    logic                n_clr;
    logic [ZI-1:0]       n_cidx;
    logic [ZCW-1:0]      n_ccnt;
    logic [ZCW-1:0]      n_cnt1;
    ppa_pkg::t_lane_ctrl n_ctrl;
    logic [1:0]          n_zmode;
    logic [ZI-1:0]       n_zidx;
    logic [ZCW-1:0]      n_zcnt;
    logic signed [23:0]  dyn_adj;
    logic signed [23:0]  stat_adj;
    logic                dyn_done;
    logic                stat_done;
    logic                rev;
    logic [22:0]         m_dyn;
    logic signed [24:0]  m_stat;
    logic signed [24:0]  m_tot;

    always_comb begin
        if (r_window == 10'd0) begin
            eff_w = WW'(1);
        end else if (EW'(r_window) > EW'(WINDOW_DEPTH)) begin
            eff_w = WW'(WINDOW_DEPTH);
        end else begin
            eff_w = WW'(r_window);
        end
    end

    assign win_clr = i_cfg_we && i_cfg_idx == ppa_pkg::REG_WINDOW;
    assign accept  = i_s_axis_tvalid && o_s_axis_tready;
    assign ack     = r_state == T_BUSY && dyn_done && stat_done &&
                     (!r_valid || i_m_axis_tready);

    always_comb begin
        n_m   = r_zmode;
        n_clr = 1'b0;
        unique case (i_s_axis_tuser)
            ppa_pkg::ZC_MANUAL: begin n_m = ZM_MANUAL; n_clr = 1'b1; end
            ppa_pkg::ZC_TIMED:  begin n_m = ZM_TIMED;  n_clr = 1'b1; end
            ppa_pkg::ZC_APPLY:  n_m = ZM_APPLY;
            ppa_pkg::ZC_CANCEL: begin n_m = ZM_IDLE;   n_clr = 1'b1; end
            default: ;
        endcase
        n_cidx  = n_clr ? '0 : r_zidx;
        n_ccnt  = n_clr ? '0 : r_zcnt;
        n_cnt1  = (n_ccnt < ZCW'(ZERO_SAMPLES)) ? n_ccnt + 1'b1 : n_ccnt;
        n_ctrl  = '0;
        n_zmode = ZM_IDLE;
        n_zidx  = '0;
        n_zcnt  = '0;
        if (n_m == ZM_MANUAL || n_m == ZM_TIMED) begin
            n_ctrl.capture = 1'b1;
            n_ctrl.clear   = n_clr;
            n_zidx  = (ZCW'(n_cidx) + ZCW'(1) >= ZCW'(ZERO_SAMPLES)) ? '0 : n_cidx + 1'b1;
            n_zcnt  = n_cnt1;
            n_zmode = (n_m == ZM_TIMED && n_cnt1 >= ZCW'(ZERO_SAMPLES)) ? ZM_APPLY : n_m;
        end else if (n_m == ZM_APPLY) begin
            n_ctrl.apply = 1'b1;
        end else begin
            n_ctrl.clear = 1'b1;
        end
    end

    ppa_lane #(.DEPTH(WINDOW_DEPTH), .ZS(ZERO_SAMPLES)) u_dyn_lane (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (accept),
        .i_ack     (ack),
        .i_win_clr (win_clr),
        .i_window  (eff_w),
        .i_gain    (r_dyn_gain),
        .i_sample  (i_s_axis_tdata[23:0]),
        .i_ctrl    (n_ctrl),
        .i_cap_idx (n_cidx),
        .o_adj     (dyn_adj),
        .o_done    (dyn_done)
    );

    ppa_lane #(.DEPTH(WINDOW_DEPTH), .ZS(ZERO_SAMPLES)) u_stat_lane (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (accept),
        .i_ack     (ack),
        .i_win_clr (win_clr),
        .i_window  (eff_w),
        .i_gain    (r_stat_gain),
        .i_sample  (i_s_axis_tdata[47:24]),
        .i_ctrl    (n_ctrl),
        .i_cap_idx (n_cidx),
        .o_adj     (stat_adj),
        .o_done    (stat_done)
    );

    always_comb begin
        rev = dyn_adj < 0;
        if (rev) begin
            m_dyn  = (dyn_adj == 24'sh800000) ? 23'h7FFFFF : 23'(-dyn_adj);
            m_stat = 25'(stat_adj) + 25'(dyn_adj);
            m_tot  = 25'(stat_adj);
        end else begin
            m_dyn  = dyn_adj[22:0];
            m_stat = 25'(stat_adj);
            m_tot  = 25'(stat_adj) + 25'(dyn_adj);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= T_IDLE;
            r_window    <= 10'd16;
            r_dyn_gain  <= 16'd16384;
            r_stat_gain <= 16'd16384;
            r_zmode     <= ZM_IDLE;
            r_zidx      <= '0;
            r_zcnt      <= '0;
            r_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    ppa_pkg::REG_WINDOW:    r_window    <= i_cfg_data[9:0];
                    ppa_pkg::REG_DYN_GAIN:  r_dyn_gain  <= i_cfg_data;
                    ppa_pkg::REG_STAT_GAIN: r_stat_gain <= i_cfg_data;
                    default: ;
                endcase
            end
            if (ack) begin
                r_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_valid <= 1'b0;
            end
            unique case (r_state)
                T_IDLE: begin
                    if (accept) begin
                        r_zmode <= n_zmode;
                        r_zidx  <= n_zidx;
                        r_zcnt  <= n_zcnt;
                        r_state <= T_BUSY;
                    end
                end
                T_BUSY: begin
                    if (ack) begin
                        r_data  <= {7'd0, m_tot, m_stat, m_dyn};
                        r_user  <= {(r_zmode == ZM_APPLY) ? 2'd2 :
                                    (r_zmode == ZM_IDLE ? 2'd0 : 2'd1), rev};
                        r_state <= T_IDLE;
                    end
                end
                default: r_state <= T_IDLE;
            endcase
        end
    end

    assign o_s_axis_tready = r_state == T_IDLE;
    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata  = r_data;
    assign o_m_axis_tuser  = r_user;

endmodule

/* sv/ppa_div.sv */
module ppa_div #(
    parameter int QW  = 33,
    parameter int DVW = 10
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [QW-1:0]    i_dividend,
    input  logic [DVW-1:0]   i_divisor,
    output logic [QW-1:0]    o_quotient,
    output logic             o_done
);

    localparam int CNTW = $clog2(QW + 1);

    logic [DVW:0]   r_rem;
    logic [QW-1:0]  r_quo;
    logic [DVW-1:0] r_div;
    logic [CNTW-1:0] r_cnt;
    logic           r_busy;
    logic           r_done;
    logic [DVW:0]   n_trial;
    logic           n_ge;

    always_comb begin
        n_trial = {r_rem[DVW-1:0], r_quo[QW-1]};
        n_ge    = n_trial >= {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && r_cnt == CNTW'(1);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(QW);
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= n_ge ? (n_trial - {1'b0, r_div}) : n_trial;
                r_quo <= {r_quo[QW-2:0], n_ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule

/* sv/ppa_lane.sv */
module ppa_lane #(
    parameter int DEPTH = 512,
    parameter int ZS    = 5
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic                         i_ack,
    input  logic                         i_win_clr,
    input  logic [$clog2(DEPTH+1)-1:0]   i_window,
    input  logic [15:0]                  i_gain,
    input  logic signed [23:0]           i_sample,
    input  ppa_pkg::t_lane_ctrl          i_ctrl,
    input  logic [(ZS>1?$clog2(ZS):1)-1:0] i_cap_idx,
    output logic signed [23:0]           o_adj,
    output logic                         o_done
);

    localparam int AW   = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam int WW   = $clog2(DEPTH + 1);
    localparam int CW   = WW + 1;
    localparam int SW   = 25 + AW;
    localparam int ZSW  = 25 + (ZS > 1 ? $clog2(ZS) : 1);
    localparam int QW   = SW > ZSW ? SW : ZSW;
    localparam int ZCW  = $clog2(ZS + 1);
    localparam int DVW  = WW > ZCW ? WW : ZCW;
    localparam int ZI   = ZS > 1 ? $clog2(ZS) : 1;
    localparam int KW   = $clog2(ZS + 1);

    // The capture sum is divided by ZS through a reciprocal multiplication
    // that is exact for every magnitude below 2**ZN.
    localparam int ZN   = ZSW - 1;
    localparam int ZL   = $clog2(ZS);
    localparam int ZSH  = ZN + ZL;
    localparam int ZMW  = ZN + 1;
    localparam int ZPW  = ZN + ZMW;
    localparam logic [ZMW-1:0] ZM = ZMW'(((64'd1 << ZSH) + 64'(ZS) - 64'd1) / 64'(ZS));

    typedef enum logic [3:0] {
        L_IDLE, L_RD, L_DIV, L_MUL, L_ADJ, L_ZSUM, L_ZDIV, L_ZOFF, L_DONE
    } t_lstate;

    t_lstate              r_state;
    logic signed [23:0]   r_mem [DEPTH];
    logic signed [23:0]   r_rd;
    logic signed [23:0]   r_smp;
    logic signed [SW-1:0] r_sum;
    logic [AW-1:0]        r_slot;
    logic [WW-1:0]        r_fill;
    logic signed [23:0]   r_off;
    logic signed [23:0]   r_zs [ZS];
    logic signed [ZSW-1:0] r_zacc;
    logic [KW-1:0]        r_k;
    logic                 r_neg;
    logic signed [23:0]   r_avg;
    logic signed [24:0]   r_x;
    logic [40:0]          r_prod;
    logic signed [23:0]   r_adj;
    ppa_pkg::t_lane_ctrl  r_ctrl;
    logic [ZI-1:0]        r_idx;
    logic                 r_dstart;
    logic [QW-1:0]        r_dnum;
    logic [DVW-1:0]       r_dden;
    logic [ZN-1:0]        r_zmag;
    logic [ZPW-1:0]       r_zprod;

    logic [QW-1:0]        div_q;
    logic                 div_done;
    logic [AW-1:0]        n_slot_c;
    logic [WW-1:0]        n_fill_c;
    logic                 n_full;
    logic signed [SW-1:0] n_sum;
    logic [AW-1:0]        n_slot;
    logic signed [QW:0]   n_qs;
    logic signed [24:0]   n_mag;
    logic signed [27:0]   n_gq;
    logic signed [47:0]   n_pre;
    logic [ZN-1:0]        n_zq;
    logic signed [47:0]   n_zoff;

    ppa_div #(.QW(QW), .DVW(DVW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_dstart),
        .i_dividend (r_dnum),
        .i_divisor  (r_dden),
        .o_quotient (div_q),
        .o_done     (div_done)
    );

    always_comb begin
        n_slot_c = (CW'(r_slot) >= CW'(i_window)) ? '0 : r_slot;
        n_fill_c = (r_fill > i_window) ? i_window : r_fill;
        n_full   = r_fill == i_window;
        n_sum    = r_sum - (n_full ? SW'(r_rd) : SW'(0)) + SW'(r_smp);
        n_slot   = (CW'(r_slot) + CW'(1) >= CW'(i_window)) ? '0 : r_slot + 1'b1;
        n_qs     = r_neg ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
        n_mag    = r_x < 0 ? -r_x : r_x;
        n_gq     = r_x < 0 ? -$signed({1'b0, r_prod[40:14]}) : $signed({1'b0, r_prod[40:14]});
        n_pre    = (i_gain >= 16'd2) ? 48'(n_gq) : 48'(r_x);
        n_zq     = ZN'(r_zprod >> ZSH);
        n_zoff   = r_neg ? $signed(48'(n_zq)) : -$signed(48'(n_zq));
    end

    always_ff @(posedge i_clk) begin
        if (r_state == L_IDLE && i_start) begin
            r_rd <= r_mem[n_slot_c];
        end
        if (r_state == L_RD) begin
            r_mem[r_slot] <= r_smp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= L_IDLE;
            r_sum    <= '0;
            r_slot   <= '0;
            r_fill   <= '0;
            r_off    <= '0;
            r_dstart <= 1'b0;
            for (int i = 0; i < ZS; i++) begin
                r_zs[i] <= '0;
            end
        end else begin
            r_dstart <= r_state == L_RD;
            if (i_win_clr) begin
                r_sum  <= '0;
                r_slot <= '0;
                r_fill <= '0;
            end
            unique case (r_state)
                L_IDLE: begin
                    if (i_start) begin
                        r_smp   <= i_sample;
                        r_slot  <= n_slot_c;
                        r_fill  <= n_fill_c;
                        r_ctrl  <= i_ctrl;
                        r_idx   <= i_cap_idx;
                        r_state <= L_RD;
                    end
                end
                L_RD: begin
                    r_sum    <= n_sum;
                    r_slot   <= n_slot;
                    r_neg    <= n_sum < 0;
                    r_dnum   <= QW'(n_sum < 0 ? -n_sum : n_sum);
                    r_dden   <= DVW'(n_full ? r_fill : r_fill + 1'b1);
                    if (!n_full) begin
                        r_fill <= r_fill + 1'b1;
                    end
                    r_state <= L_DIV;
                end
                L_DIV: begin
                    if (div_done) begin
                        r_avg   <= n_qs[23:0];
                        r_x     <= 25'($signed(n_qs[23:0])) + 25'(r_off);
                        r_state <= L_MUL;
                    end
                end
                L_MUL: begin
                    r_prod  <= 41'(n_mag) * 41'(i_gain);
                    r_state <= L_ADJ;
                end
                L_ADJ: begin
                    r_adj <= ppa_pkg::f_sat24(n_pre);
                    if (r_ctrl.apply) begin
                        r_zacc  <= '0;
                        r_k     <= '0;
                        r_state <= L_ZSUM;
                    end else begin
                        for (int i = 0; i < ZS; i++) begin
                            if (r_ctrl.capture && ZI'(i) == r_idx) begin
                                r_zs[i] <= r_avg;
                            end else if (r_ctrl.clear) begin
                                r_zs[i] <= '0;
                            end
                        end
                        r_state <= L_DONE;
                    end
                end
                L_ZSUM: begin
                    if (r_k == KW'(ZS)) begin
                        r_neg   <= r_zacc < 0;
                        r_zmag  <= ZN'(r_zacc < 0 ? -r_zacc : r_zacc);
                        r_state <= L_ZDIV;
                    end else begin
                        r_zacc <= r_zacc + ZSW'(r_zs[r_k[ZI-1:0]]);
                        r_k    <= r_k + 1'b1;
                    end
                end
                L_ZDIV: begin
                    r_zprod <= ZPW'(r_zmag) * ZPW'(ZM);
                    r_state <= L_ZOFF;
                end
                L_ZOFF: begin
                    r_off <= ppa_pkg::f_sat24(n_zoff);
                    for (int i = 0; i < ZS; i++) begin
                        r_zs[i] <= '0;
                    end
                    r_state <= L_DONE;
                end
                L_DONE: begin
                    if (i_ack) begin
                        r_state <= L_IDLE;
                    end
                end
                default: r_state <= L_IDLE;
            endcase
        end
    end

    assign o_adj  = r_adj;
    assign o_done = r_state == L_DONE;

endmodule
